// ----- rtl/core/sap_pkg.sv -----
// Package for the stereo allpass phaser: widths, register indexes, sequencer states
// and the fixed-point round/saturate helpers. No dependencies.
`timescale 1ns / 1ps

package sap_pkg;

  localparam int MAX_STAGES  = 16;
  localparam int SAMPLE_W    = 16;
  localparam int INT_W       = SAMPLE_W + 4;   // Q5.15 internal values
  localparam int FRAC        = 15;
  localparam int COEF_W      = 16;
  localparam int STAGE_CNT_W = 5;
  localparam int CFG_DATA_W  = 16;

  localparam int HIST_DEPTH = 2 * MAX_STAGES;  // entry = 2*stage + channel
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int STAGE_W    = HIST_AW - 1;
  localparam int HIST_W     = 2 * INT_W;       // {input history, output history}

  localparam int MUL_A_W = COEF_W + 1;         // coefficient, gain or wet mix
  localparam int MUL_B_W = INT_W + 1;          // feedback value, or difference or sum of two values
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - FRAC + 1;
  localparam int SUM_W   = RND_W + 1;

  localparam logic [STAGE_CNT_W-1:0] MAX_STAGES_C  = STAGE_CNT_W'(MAX_STAGES);
  localparam logic [STAGE_CNT_W-1:0] STAGES_RESET  = STAGE_CNT_W'(4);
  localparam logic [COEF_W-1:0]      WET_FULL      = 16'h8000;
  localparam logic [COEF_W-1:0]      WET_RESET     = 16'h4000;

  localparam logic signed [SUM_W-1:0] INT_MAX =
    {{(SUM_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] INT_MIN =
    {{(SUM_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SMP_MAX =
    {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMP_MIN =
    {{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_COEF    = 2'd0,
    CFG_FB_GAIN = 2'd1,
    CFG_WET     = 2'd2,
    CFG_STAGES  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_ADD,
    ST_AP_MUL,
    ST_AP_ACC,
    ST_SUM_MUL,
    ST_MIX_L,
    ST_MIX_R,
    ST_DONE
  } state_e;

  // round to nearest, ties up: add half then floor shift
  function automatic logic signed [RND_W-1:0] rnd15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (FRAC - 1));
    return t[PROD_W:FRAC];
  endfunction

  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << FRAC);
    return {t[PROD_W], t[PROD_W:FRAC+1]};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_rnd(input logic signed [RND_W-1:0] v);
    return {v[RND_W-1], v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_int(input logic signed [INT_W-1:0] v);
    return {{(SUM_W-INT_W){v[INT_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_smp(input logic signed [SAMPLE_W-1:0] v);
    return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] v);
    logic signed [INT_W-1:0] r;
    if (v > INT_MAX) begin
      r = INT_MAX[INT_W-1:0];
    end else if (v < INT_MIN) begin
      r = INT_MIN[INT_W-1:0];
    end else begin
      r = v[INT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_W-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sap_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sap_mul.sv -----
// Shared signed multiplier with a registered product; used for every product
// of the phaser. Depends on sap_pkg.
`timescale 1ns / 1ps

module sap_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [sap_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [sap_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [sap_pkg::PROD_W-1:0]   p_o
);

  logic signed [sap_pkg::PROD_W-1:0] p_q;

  // product holds while en_i is low
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/stereo_allpass_phaser_top.sv -----
// Top level of the stereo allpass phaser: sequencer, history RAM, config registers.
// Depends on sap_pkg, sap_mul and sap_ram.
`timescale 1ns / 1ps

// Stereo phaser. Each input transfer carries one Q1.15 left/right pair; the block
// adds the mono feedback term, runs each channel through stage_count first-order
// allpass sections (each stage and channel with its own history), forms the next
// feedback value and returns one dry/wet mixed output pair, saturated to Q1.15.
// Internal values are Q5.15 in 20 bits and saturate. The stage count in use is
// capped at 16. All products go through the single shared 17x21 multiplier, one
// after another: the feedback product, then per stage and channel a multiply step
// and an accumulate-and-history-write step, then the next feedback and mix products.
// in_stall_o is high while an item is at work. A finished result sits in the
// output register, so the next input is taken while it waits; the block stalls
// only if a second result is ready before the first one has transferred.
// Stage history lives in a 32-entry RAM with one valid flag per entry, so reset
// takes effect at once, with no clearing pass. Config writes go through the plain
// write port and must only happen while the block is idle.

module stereo_allpass_phaser_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sap_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [sap_pkg::SAMPLE_W-1:0] in_right_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sap_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [sap_pkg::SAMPLE_W-1:0] out_right_o,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [sap_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic signed [sap_pkg::COEF_W-1:0]      coef_q;
  logic signed [sap_pkg::COEF_W-1:0]      gain_q;
  logic [sap_pkg::COEF_W-1:0]             wet_q;
  logic [sap_pkg::STAGE_CNT_W-1:0]        stages_q;
  sap_pkg::cfg_idx_e                      cfg_idx;

  assign cfg_idx = sap_pkg::cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      gain_q   <= '0;
      wet_q    <= sap_pkg::WET_RESET;
      stages_q <= sap_pkg::STAGES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        sap_pkg::CFG_COEF:    coef_q   <= cfg_data_i;
        sap_pkg::CFG_FB_GAIN: gain_q   <= cfg_data_i;
        sap_pkg::CFG_WET:     wet_q    <= cfg_data_i;
        sap_pkg::CFG_STAGES:  stages_q <= cfg_data_i[sap_pkg::STAGE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped stage count and wet fraction
  logic [sap_pkg::STAGE_CNT_W-1:0] stages_use;
  logic [sap_pkg::STAGE_CNT_W-1:0] stages_m1;
  logic [sap_pkg::HIST_AW-1:0]     idx_last;
  logic [sap_pkg::COEF_W-1:0]      wet_use;

  assign stages_use = (stages_q > sap_pkg::MAX_STAGES_C) ? sap_pkg::MAX_STAGES_C : stages_q;
  assign stages_m1  = stages_use - sap_pkg::STAGE_CNT_W'(1);
  assign idx_last   = {stages_m1[sap_pkg::STAGE_W-1:0], 1'b1};
  assign wet_use    = (wet_q > sap_pkg::WET_FULL) ? sap_pkg::WET_FULL : wet_q;

  // ---------------------------------------------------------------------------
  // Datapath state
  // ---------------------------------------------------------------------------
  sap_pkg::state_e state_q, state_d;

  logic [sap_pkg::HIST_AW-1:0]            idx_q, idx_d;
  logic signed [sap_pkg::SAMPLE_W-1:0]    dry_q [2];
  logic signed [sap_pkg::SAMPLE_W-1:0]    dry_d [2];
  logic signed [sap_pkg::INT_W-1:0]       x_q [2];
  logic signed [sap_pkg::INT_W-1:0]       x_d [2];
  logic signed [sap_pkg::INT_W-1:0]       xh_q, xh_d;
  logic signed [sap_pkg::INT_W-1:0]       fb_q, fb_d;
  logic signed [sap_pkg::SAMPLE_W-1:0]    res_l_q, res_l_d;
  logic signed [sap_pkg::SAMPLE_W-1:0]    out_l_q, out_l_d;
  logic signed [sap_pkg::SAMPLE_W-1:0]    out_r_q, out_r_d;
  logic                                   out_vld_q, out_vld_d;

  // history RAM and per-entry valid flags (entry not yet written reads as zero)
  logic [sap_pkg::HIST_DEPTH-1:0] hist_vld_q;
  logic                           vld_rd_q;
  logic                           ram_we, ram_re;
  logic [sap_pkg::HIST_AW-1:0]    ram_raddr;
  logic [sap_pkg::HIST_W-1:0]     ram_wdata, ram_rdata;

  // shared multiplier
  logic                                 mul_en;
  logic signed [sap_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [sap_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [sap_pkg::PROD_W-1:0]   prod;

  sap_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  sap_ram #(
    .WIDTH (sap_pkg::HIST_W),
    .DEPTH (sap_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // history read for the current entry
  logic                             ch;
  logic signed [sap_pkg::INT_W-1:0] xh_rd, yh_rd;
  logic signed [sap_pkg::RND_W-1:0] prod_r15;
  logic signed [sap_pkg::INT_W-1:0] y_new;

  assign ch       = idx_q[0];
  assign xh_rd    = vld_rd_q ? ram_rdata[sap_pkg::HIST_W-1:sap_pkg::INT_W] : '0;
  assign yh_rd    = vld_rd_q ? ram_rdata[sap_pkg::INT_W-1:0] : '0;
  assign prod_r15 = sap_pkg::rnd15(prod);
  assign y_new    = sap_pkg::sat_int(sap_pkg::sx_int(xh_q) + sap_pkg::sx_rnd(prod_r15));

  assign ram_wdata = {x_q[ch], y_new};
  assign in_stall_o = (state_q != sap_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    dry_d     = dry_q;
    x_d       = x_q;
    xh_d      = xh_q;
    fb_d      = fb_q;
    res_l_d   = res_l_q;
    out_l_d   = out_l_q;
    out_r_d   = out_r_q;
    out_vld_d = out_vld_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    // result taken downstream
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      sap_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          dry_d[0] = in_left_i;
          dry_d[1] = in_right_i;
          idx_d    = '0;
          state_d  = sap_pkg::ST_FB_MUL;
        end
      end

      sap_pkg::ST_FB_MUL: begin
        mul_en  = 1'b1;
        mul_a   = {gain_q[sap_pkg::COEF_W-1], gain_q};
        mul_b   = {fb_q[sap_pkg::INT_W-1], fb_q};
        state_d = sap_pkg::ST_FB_ADD;
      end

      sap_pkg::ST_FB_ADD: begin
        x_d[0] = sap_pkg::sat_int(sap_pkg::sx_smp(dry_q[0]) + sap_pkg::sx_rnd(prod_r15));
        x_d[1] = sap_pkg::sat_int(sap_pkg::sx_smp(dry_q[1]) + sap_pkg::sx_rnd(prod_r15));
        if (stages_use == '0) begin
          state_d = sap_pkg::ST_SUM_MUL;
        end else begin
          ram_re  = 1'b1;
          state_d = sap_pkg::ST_AP_MUL;
        end
      end

      // a * (yh - x)
      sap_pkg::ST_AP_MUL: begin
        xh_d    = xh_rd;
        mul_en  = 1'b1;
        mul_a   = {coef_q[sap_pkg::COEF_W-1], coef_q};
        mul_b   = {yh_rd[sap_pkg::INT_W-1], yh_rd} - {x_q[ch][sap_pkg::INT_W-1], x_q[ch]};
        state_d = sap_pkg::ST_AP_ACC;
      end

      // y = xh + round(prod); history update; prefetch next entry
      sap_pkg::ST_AP_ACC: begin
        ram_we  = 1'b1;
        x_d[ch] = y_new;
        if (idx_q == idx_last) begin
          state_d = sap_pkg::ST_SUM_MUL;
        end else begin
          idx_d     = idx_q + sap_pkg::HIST_AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + sap_pkg::HIST_AW'(1);
          state_d   = sap_pkg::ST_AP_MUL;
        end
      end

      sap_pkg::ST_SUM_MUL: begin
        mul_en  = 1'b1;
        mul_a   = {gain_q[sap_pkg::COEF_W-1], gain_q};
        mul_b   = {x_q[0][sap_pkg::INT_W-1], x_q[0]} + {x_q[1][sap_pkg::INT_W-1], x_q[1]};
        state_d = sap_pkg::ST_MIX_L;
      end

      sap_pkg::ST_MIX_L: begin
        fb_d    = sap_pkg::sat_int(sap_pkg::sx_rnd(sap_pkg::rnd16(prod)));
        mul_en  = 1'b1;
        mul_a   = {1'b0, wet_use};
        mul_b   = {x_q[0][sap_pkg::INT_W-1], x_q[0]} -
                  {{(sap_pkg::MUL_B_W-sap_pkg::SAMPLE_W){dry_q[0][sap_pkg::SAMPLE_W-1]}},
                   dry_q[0]};
        state_d = sap_pkg::ST_MIX_R;
      end

      sap_pkg::ST_MIX_R: begin
        res_l_d = sap_pkg::sat_smp(sap_pkg::sx_smp(dry_q[0]) + sap_pkg::sx_rnd(prod_r15));
        mul_en  = 1'b1;
        mul_a   = {1'b0, wet_use};
        mul_b   = {x_q[1][sap_pkg::INT_W-1], x_q[1]} -
                  {{(sap_pkg::MUL_B_W-sap_pkg::SAMPLE_W){dry_q[1][sap_pkg::SAMPLE_W-1]}},
                   dry_q[1]};
        state_d = sap_pkg::ST_DONE;
      end

      // wait for the output register to be free; product holds meanwhile
      sap_pkg::ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_l_d   = res_l_q;
          out_r_d   = sap_pkg::sat_smp(sap_pkg::sx_smp(dry_q[1]) +
                                       sap_pkg::sx_rnd(prod_r15));
          out_vld_d = 1'b1;
          state_d   = sap_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sap_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sap_pkg::ST_IDLE;
      idx_q      <= '0;
      fb_q       <= '0;
      out_vld_q  <= 1'b0;
      hist_vld_q <= '0;
      vld_rd_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      fb_q      <= fb_d;
      out_vld_q <= out_vld_d;
      if (ram_we) begin
        hist_vld_q[idx_q] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= hist_vld_q[ram_raddr];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dry_q   <= dry_d;
    x_q     <= x_d;
    xh_q    <= xh_d;
    res_l_q <= res_l_d;
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

endmodule

// ----- dv/tb_stereo_allpass_phaser_top.sv -----
// Self-checking testbench for stereo_allpass_phaser_top: random and directed sample pairs,
// a scoreboard class that predicts each mixed output pair. Depends on sap_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [sap_pkg::SAMPLE_W-1:0] left;
  logic signed [sap_pkg::SAMPLE_W-1:0] right;
} stereo_pair_t;

// Tracks register settings and allpass history, predicts the output pair of every
// accepted input pair and checks the block's results against them in order.
class phaser_scoreboard;
  longint       coef_q15;
  longint       gain_q15;
  longint       wet_q15;
  longint       stages_req;
  longint       in_hist [2*sap_pkg::MAX_STAGES];
  longint       out_hist[2*sap_pkg::MAX_STAGES];
  longint       fb_state;
  stereo_pair_t pending_mixes[$];
  int           errors;

  function new();
    coef_q15   = 0;
    gain_q15   = 0;
    wet_q15    = 16384;
    stages_req = 4;
    fb_state   = 0;
    errors     = 0;
    foreach (in_hist[i]) begin
      in_hist[i]  = 0;
      out_hist[i] = 0;
    end
  endfunction

  static function longint clamp_to(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // round half up, then floor shift
  static function longint round_down_by(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function void write_reg(sap_pkg::cfg_idx_e idx, logic [sap_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      sap_pkg::CFG_COEF:    coef_q15   = longint'($signed(d));
      sap_pkg::CFG_FB_GAIN: gain_q15   = longint'($signed(d));
      sap_pkg::CFG_WET:     wet_q15    = longint'(d);
      sap_pkg::CFG_STAGES:  stages_req = longint'(d[sap_pkg::STAGE_CNT_W-1:0]);
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_mixes.size();
  endfunction

  // Runs one pair through feedback, the allpass cascade and the dry/wet mix.
  function void accept_pair(logic signed [sap_pkg::SAMPLE_W-1:0] l,
                            logic signed [sap_pkg::SAMPLE_W-1:0] r);
    longint       dry[2];
    longint       v[2];
    longint       fb_term, y, o, n_stages, mix;
    int           e;
    stereo_pair_t p;
    n_stages = (stages_req > sap_pkg::MAX_STAGES) ? sap_pkg::MAX_STAGES : stages_req;
    mix      = (wet_q15 > 32768) ? 32768 : wet_q15;
    dry[0]   = l;
    dry[1]   = r;
    fb_term  = round_down_by(gain_q15 * fb_state, sap_pkg::FRAC);
    for (int ch = 0; ch < 2; ch++) v[ch] = clamp_to(dry[ch] + fb_term, sap_pkg::INT_W);
    for (int k = 0; k < n_stages; k++) begin
      for (int ch = 0; ch < 2; ch++) begin
        e = 2 * k + ch;
        y = clamp_to(in_hist[e] +
                     round_down_by(coef_q15 * (out_hist[e] - v[ch]), sap_pkg::FRAC),
                     sap_pkg::INT_W);
        in_hist[e]  = v[ch];
        out_hist[e] = y;
        v[ch]       = y;
      end
    end
    fb_state = clamp_to(round_down_by((v[0] + v[1]) * gain_q15, sap_pkg::FRAC + 1),
                        sap_pkg::INT_W);
    o = clamp_to(dry[0] + round_down_by(mix * (v[0] - dry[0]), sap_pkg::FRAC),
                 sap_pkg::SAMPLE_W);
    p.left = o[sap_pkg::SAMPLE_W-1:0];
    o = clamp_to(dry[1] + round_down_by(mix * (v[1] - dry[1]), sap_pkg::FRAC),
                 sap_pkg::SAMPLE_W);
    p.right = o[sap_pkg::SAMPLE_W-1:0];
    pending_mixes.push_back(p);
  endfunction

  function void check_mix(logic signed [sap_pkg::SAMPLE_W-1:0] l,
                          logic signed [sap_pkg::SAMPLE_W-1:0] r);
    stereo_pair_t p;
    if (pending_mixes.size() == 0) begin
      errors++;
      $display("%0t: unexpected output pair %0d / %0d", $time, l, r);
      return;
    end
    p = pending_mixes.pop_front();
    if (l !== p.left) begin
      errors++;
      $display("%0t: out_left expected %0d actual %0d", $time, p.left, l);
    end
    if (r !== p.right) begin
      errors++;
      $display("%0t: out_right expected %0d actual %0d", $time, p.right, r);
    end
  endfunction
endclass

module tb_stereo_allpass_phaser_top;

  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam int     HOLD_CYCLES = 300;
  localparam int     PHASES      = 12;
  localparam int     PHASE_ITEMS = 128;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [sap_pkg::SAMPLE_W-1:0] in_left_i;
  logic signed [sap_pkg::SAMPLE_W-1:0] in_right_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [sap_pkg::SAMPLE_W-1:0] out_left_o;
  logic signed [sap_pkg::SAMPLE_W-1:0] out_right_o;
  logic                                cfg_we_i;
  logic [1:0]                          cfg_idx_i;
  logic [sap_pkg::CFG_DATA_W-1:0]      cfg_data_i;

  phaser_scoreboard sb;

  // percent of cycles each side idles; a hold request freezes the receiver
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_req;
  longint cycle_count;

  stereo_allpass_phaser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: every transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_mix(out_left_o, out_right_o);
  end

  // Receiver stall, changed on the falling edge. A hold request keeps it high for a
  // counted stretch so the output register fills and the input side backs up.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic signed [sap_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return sap_pkg::SAMPLE_W'($urandom_range(511)) - sap_pkg::SAMPLE_W'(256);
      default: return sap_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_pair(input logic signed [sap_pkg::SAMPLE_W-1:0] l,
                           input logic signed [sap_pkg::SAMPLE_W-1:0] r);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_left_i  <= l;
    in_right_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.accept_pair(l, r);
    @(negedge clk_i);
  endtask

  // Writes all four registers, one per cycle; only used with the block idle.
  task automatic program_regs(input logic [sap_pkg::CFG_DATA_W-1:0] coef,
                              input logic [sap_pkg::CFG_DATA_W-1:0] gain,
                              input logic [sap_pkg::CFG_DATA_W-1:0] wet,
                              input logic [sap_pkg::CFG_DATA_W-1:0] stages);
    sap_pkg::cfg_idx_e              order[4];
    logic [sap_pkg::CFG_DATA_W-1:0] vals[4];
    order = '{sap_pkg::CFG_COEF, sap_pkg::CFG_FB_GAIN, sap_pkg::CFG_WET,
              sap_pkg::CFG_STAGES};
    vals  = '{coef, gain, wet, stages};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[i];
      cfg_data_i <= vals[i];
      sb.write_reg(order[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Sender pause: nothing moves until every predicted pair has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [sap_pkg::CFG_DATA_W-1:0] coef, gain, wet, stages;
    sb            = new();
    send_idle_pct = 26;
    recv_idle_pct = 84;
    hold_req      = 0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_left_i     = '0;
    in_right_i    = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sap_pkg::CFG_COEF;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings first (4 stages, half wet, no feedback).
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0001, 16'shFFFF);
    drain();
    // Full cascade, maximum coefficient, most negative gain, fully wet.
    program_regs(16'h7FFF, 16'h8000, sap_pkg::WET_FULL, 16'd16);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'shFFFF, 16'sh0001);
    drain();
    // Stage count above the maximum (upper data bits set too), wet above full.
    program_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    drain();
    // Zero stages: cascade is a pass-through; dry only output.
    program_regs(16'h1234, 16'h4000, 16'h0000, 16'hFFE0);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh4000, 16'shC000);
    send_pair(16'sh8000, 16'sh7FFF);
    drain();
    // One stage, negative coefficient of smallest magnitude, tiny gain, wet above full.
    program_regs(16'hFFFF, 16'h0001, 16'd40000, 16'd1);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh0000);
    send_pair(16'sh0123, 16'shFEDC);
    drain();

    // Random phases: fresh settings each time, idling pattern changes per third.
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 84;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0:       coef = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: coef = sap_pkg::CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(3))
        0:       gain = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        1:       gain = 16'h0000;
        default: gain = sap_pkg::CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(4))
        0:       wet = 16'h0000;
        1:       wet = sap_pkg::WET_FULL;
        2:       wet = sap_pkg::CFG_DATA_W'($urandom_range(16'hFFFF, 16'h8001));
        default: wet = sap_pkg::CFG_DATA_W'($urandom_range(32768));
      endcase
      stages = {sap_pkg::CFG_DATA_W'($urandom_range(2047)) << sap_pkg::STAGE_CNT_W}
               | sap_pkg::CFG_DATA_W'($urandom_range(31));
      program_regs(coef, gain, wet, stages);
      // long receiver hold while the sender keeps offering
      if (p == 1 || p == PHASES - 2) hold_req = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) send_pair(random_sample(), random_sample());
      drain();
    end

    // Tail: allow a late or stray result to show up before the verdict.
    repeat (4 * sap_pkg::MAX_STAGES + 40) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
